[rtl/core/sidec_pkg.sv]
// Shared constants and types for the signed integer to decimal ASCII converter.
package sidec_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;

    localparam int BCD_BITS   = MAX_DIGITS * 4;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int DIG_BITS   = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] DIGIT_FIVE = 4'd5;
    localparam logic [3:0] DIGIT_NINE = 4'd9;
    localparam logic [3:0] DIGIT_ADJ  = 4'd3;

    localparam logic [BCD_BITS-1:0] BCD_NINES = {MAX_DIGITS{DIGIT_NINE}};

    typedef logic [BCD_BITS-1:0] bcd_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_STRIP   = 5'b00100,
        ST_SIGN    = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

endpackage

[rtl/core/sidec_dabble.sv]
// One shift-and-add-3 step of the binary to BCD conversion.
module sidec_dabble
(
    input  sidec_pkg::bcd_t bcd,
    input  logic            shift_in,
    output sidec_pkg::bcd_t bcd_out,
    output logic            carry_out
);

    sidec_pkg::bcd_t adjusted;

    // Each digit that would reach ten or more after doubling is corrected first.
    always_comb
    begin
        for (int i = 0; i < sidec_pkg::MAX_DIGITS; i++)
        begin
            if (bcd[i*4 +: 4] >= sidec_pkg::DIGIT_FIVE)
            begin
                adjusted[i*4 +: 4] = bcd[i*4 +: 4] + sidec_pkg::DIGIT_ADJ;
            end
            else
            begin
                adjusted[i*4 +: 4] = bcd[i*4 +: 4];
            end
        end
    end

    assign bcd_out   = {adjusted[sidec_pkg::BCD_BITS-2:0], shift_in};
    assign carry_out = adjusted[sidec_pkg::BCD_BITS-1];

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter with its sequencer.
//
// The block takes one two's-complement integer per input transfer and returns
// its decimal text, one ASCII character per output transfer, most significant
// character first: an optional '-', then the digits with no leading zeros
// (zero gives a single '0'), with last set on the final character. The most
// negative value converts exactly. A number is taken in, then its magnitude
// passes bit by bit through the shared shift-and-add-3 step, then the leading
// zero digits are dropped one at a time until the first digit is found, and
// then one character is loaded into the output register whenever it is free.
// The dropped zeros and the emitted digits always add up to MAX_DIGITS. While
// a number is in work, in_stall is high; the next number is taken as soon as
// the final character is in the output register, even if that character
// still waits for its transfer. Should a magnitude need more digits than
// MAX_DIGITS, the digit string saturates to all nines.
module signed_int_to_decimal_ascii
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sidec_pkg::VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        character,
    output logic                              last
);

    sidec_pkg::state_t state_reg, state_next;

    logic [sidec_pkg::VALUE_BITS-1:0] mag_reg, mag_next;
    sidec_pkg::bcd_t                  bcd_reg, bcd_next;
    logic                             ovf_reg, ovf_next;
    logic                             neg_reg, neg_next;
    logic [sidec_pkg::CNT_BITS-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [sidec_pkg::DIG_BITS-1:0]   ndig_reg, ndig_next;

    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       char_reg, char_next;
    logic                             last_reg, last_next;

    sidec_pkg::bcd_t                  step_bcd;
    logic                             step_carry;
    logic                             in_accept;
    logic                             slot_free;
    logic [3:0]                       top_digit;
    logic [sidec_pkg::VALUE_BITS-1:0] value_bits;

    // The shared arithmetic unit: one bit of the magnitude enters per cycle.
    sidec_dabble u_dabble
    (
        .bcd       (bcd_reg),
        .shift_in  (mag_reg[sidec_pkg::VALUE_BITS-1]),
        .bcd_out   (step_bcd),
        .carry_out (step_carry)
    );

    assign value_bits = value;
    assign in_stall   = (state_reg != sidec_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    // The output register may be loaded when it is empty or being drained.
    assign slot_free  = !out_valid_reg || !out_stall;
    assign top_digit  = bcd_reg[sidec_pkg::BCD_BITS-1 -: 4];

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        ndig_next      = ndig_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;

        case (state_reg)
            sidec_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next     = value_bits[sidec_pkg::VALUE_BITS-1];
                    // Negating the most negative value leaves its exact magnitude
                    // when read as unsigned.
                    mag_next     = value_bits[sidec_pkg::VALUE_BITS-1] ?
                                   (~value_bits + 1'b1) : value_bits;
                    bcd_next     = '0;
                    ovf_next     = 1'b0;
                    bit_cnt_next = sidec_pkg::CNT_BITS'(sidec_pkg::VALUE_BITS);
                    state_next   = sidec_pkg::ST_CONVERT;
                end
            end
            sidec_pkg::ST_CONVERT:
            begin
                mag_next     = {mag_reg[sidec_pkg::VALUE_BITS-2:0], 1'b0};
                bcd_next     = step_bcd;
                ovf_next     = ovf_reg || step_carry;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == sidec_pkg::CNT_BITS'(1))
                begin
                    if (ovf_reg || step_carry)
                    begin
                        bcd_next = sidec_pkg::BCD_NINES;
                    end
                    ndig_next  = sidec_pkg::DIG_BITS'(sidec_pkg::MAX_DIGITS);
                    state_next = sidec_pkg::ST_STRIP;
                end
            end
            sidec_pkg::ST_STRIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if ((top_digit == 4'd0) && (ndig_reg != sidec_pkg::DIG_BITS'(1)))
                begin
                    bcd_next  = {bcd_reg[sidec_pkg::BCD_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = sidec_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sidec_pkg::ST_EMIT;
                end
            end
            sidec_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sidec_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = sidec_pkg::ST_EMIT;
                end
            end
            sidec_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sidec_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_next      = (ndig_reg == sidec_pkg::DIG_BITS'(1));
                    bcd_next       = {bcd_reg[sidec_pkg::BCD_BITS-5:0], 4'd0};
                    ndig_next      = ndig_reg - 1'b1;
                    if (ndig_reg == sidec_pkg::DIG_BITS'(1))
                    begin
                        state_next = sidec_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sidec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sidec_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers hold no control meaning and need no reset.
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        ovf_reg     <= ovf_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == sidec_pkg::ST_CONVERT))
        else $error("accepted number did not start conversion");

    a_convert_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sidec_pkg::ST_CONVERT) && (bit_cnt_reg == sidec_pkg::CNT_BITS'(1)))
        |=> (state_reg == sidec_pkg::ST_STRIP))
        else $error("conversion did not end after the last bit");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sidec_pkg::ST_EMIT) |-> (ndig_reg != '0))
        else $error("emitting with no digits left");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |->
        ((char_reg >= sidec_pkg::CHAR_ZERO) &&
         (char_reg <= sidec_pkg::CHAR_ZERO + 8'd9)))
        else $error("final character is not a digit");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the signed integer to decimal ASCII converter.
module testbench;

    // One character of decimal text as it appears on the output transfer.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } ascii_char_t;

    // A directed row holds the number to send. Where the text can be read off
    // at a glance it is typed in, otherwise the string is empty and the
    // expected text comes from the local conversion function.
    typedef struct {
        logic signed [sidec_pkg::VALUE_BITS-1:0] num;
        string                                   text;
    } stim_row_t;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int N_DIRECTED     = 20;
    localparam int N_RANDOM       = 130;
    localparam int N_TOTAL        = N_DIRECTED + N_RANDOM;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam longint MAX_POS_MAG = (64'd1 << (sidec_pkg::VALUE_BITS - 1)) - 1;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_stall;
    logic signed [sidec_pkg::VALUE_BITS-1:0] value;
    logic                                    out_valid;
    logic                                    out_stall;
    logic [7:0]                              character;
    logic                                    last;

    // Expected characters, oldest first, across all numbers in flight.
    ascii_char_t pending_text[$];

    int error_count    = 0;
    int numbers_sent   = 0;
    int negatives_sent = 0;
    int chars_checked  = 0;
    int longest_text   = 0;
    int idle_cycles    = 0;

    // The directed rows cover zero, single digits, digit-count boundaries, both
    // extremes of the range (the most negative value among them), and
    // alternating bit patterns so that every input bit is seen at 0 and 1.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'sd0,          "0"},
        '{32'sd1,          "1"},
        '{-32'sd1,         "-1"},
        '{32'sd9,          "9"},
        '{32'sd10,         "10"},
        '{-32'sd10,        ""},
        '{32'sd99,         ""},
        '{-32'sd100,       ""},
        '{32'sh7FFFFFFF,   "2147483647"},
        '{32'sh80000000,   "-2147483648"},
        '{-32'sd2147483647, ""},
        '{32'sd1000000000, ""},
        '{32'sd999999999,  ""},
        '{-32'sd999999999, ""},
        '{32'sd1234567890, ""},
        '{32'sh55555555,   ""},
        '{32'shAAAAAAAA,   ""},
        '{32'sd7,          ""},
        '{-32'sd1000000,   ""},
        '{32'sd42,         ""}
    };

    signed_int_to_decimal_ascii i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Counts an error and prints it while the report budget lasts.
    task automatic note_error(input string msg);
        if (error_count < REPORT_LIMIT)
        begin
            $display("ERROR: %s", msg);
        end
        error_count++;
    endtask

    // Appends the decimal text of one number to the expectation queue and
    // returns how many characters it has. The magnitude is taken one bit wider
    // than the value so that the most negative number converts exactly.
    function automatic int queue_decimal_text(
        input logic signed [sidec_pkg::VALUE_BITS-1:0] num);
        logic                           neg;
        logic [sidec_pkg::VALUE_BITS:0] mag;
        logic [3:0]                     digits[$];
        int                             n_chars;
        neg     = num[sidec_pkg::VALUE_BITS-1];
        mag     = neg ? ({1'b0, ~num} + 1'b1) : {1'b0, num};
        n_chars = 0;
        if (mag == 0)
        begin
            pending_text.push_back(ascii_char_t'{sidec_pkg::CHAR_ZERO, 1'b1});
            return 1;
        end
        while (mag != 0)
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        // A magnitude wider than the digit field saturates to all nines.
        if (digits.size() > sidec_pkg::MAX_DIGITS)
        begin
            digits.delete();
            repeat (sidec_pkg::MAX_DIGITS) digits.push_back(sidec_pkg::DIGIT_NINE);
        end
        if (neg)
        begin
            pending_text.push_back(ascii_char_t'{sidec_pkg::CHAR_MINUS, 1'b0});
            n_chars++;
        end
        foreach (digits[i])
        begin
            pending_text.push_back(ascii_char_t'{sidec_pkg::CHAR_ZERO + 8'(digits[i]),
                                                 i == digits.size() - 1});
            n_chars++;
        end
        return n_chars;
    endfunction

    // Appends a typed-in expected text to the expectation queue.
    function automatic int queue_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            pending_text.push_back(ascii_char_t'{8'(text[i]), i == text.len() - 1});
        end
        return text.len();
    endfunction

    // Random numbers: most pick a digit count first so that short and long
    // texts are equally likely, the rest hit raw bit patterns, powers of ten and
    // the values just below them, tiny values and the ends of the range.
    function automatic logic signed [sidec_pkg::VALUE_BITS-1:0] random_value();
        int     kind;
        int     n_digits;
        logic   neg;
        longint lo;
        longint hi;
        longint mag;
        kind = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        hi   = neg ? MAX_POS_MAG + 1 : MAX_POS_MAG;
        if (kind == 6)
        begin
            return $urandom;
        end
        if (kind <= 5)
        begin
            n_digits = $urandom_range(1, sidec_pkg::MAX_DIGITS);
            lo = 1;
            repeat (n_digits - 1) lo = lo * 10;
            if (lo * 10 - 1 < hi)
            begin
                hi = lo * 10 - 1;
            end
            mag = lo + longint'($urandom) % (hi - lo + 1);
        end
        else if (kind == 7)
        begin
            mag = 1;
            repeat ($urandom_range(0, sidec_pkg::MAX_DIGITS - 1)) mag = mag * 10;
            mag = mag - $urandom_range(0, 1);
        end
        else if (kind == 8)
        begin
            mag = $urandom_range(0, 20);
        end
        else
        begin
            mag = hi - $urandom_range(0, 15);
        end
        return sidec_pkg::VALUE_BITS'(neg ? -mag : mag);
    endfunction

    // Sender: numbers go out in bursts of random length. Between bursts valid
    // drops for a random gap. Within a burst valid stays high and the next
    // number is presented in the same step as the transfer of the previous one.
    initial
    begin
        int                                      row;
        int                                      burst_left;
        int                                      n_chars;
        logic signed [sidec_pkg::VALUE_BITS-1:0] num;
        in_valid <= 1'b0;
        value    <= '0;
        rst_n    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 20);
        for (row = 0; row < N_TOTAL; row++)
        begin
            num      = (row < N_DIRECTED) ? directed_rows[row].num : random_value();
            in_valid <= 1'b1;
            value    <= num;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            // The transfer happened at this edge.
            if (row < N_DIRECTED && directed_rows[row].text.len() != 0)
            begin
                n_chars = queue_typed_text(directed_rows[row].text);
            end
            else
            begin
                n_chars = queue_decimal_text(num);
            end
            numbers_sent++;
            if (num < 0)
            begin
                negatives_sent++;
            end
            if (n_chars > longest_text)
            begin
                longest_text = n_chars;
            end
            burst_left--;
            if (burst_left == 0 || row == N_TOTAL - 1)
            begin
                in_valid <= 1'b0;
            end
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 25)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
        while (pending_text.size() != 0) @(posedge clk);
        // Let any stray characters show up before the final verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_text.size() != 0)
        begin
            note_error($sformatf("%0d expected characters never arrived",
                                 pending_text.size()));
        end
        $display("Converted %0d numbers (%0d negative), checked %0d characters,",
                 numbers_sent, negatives_sent, chars_checked);
        $display("longest text %0d characters, with bursty input and patterned output stalls.",
                 longest_text);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: the stall pattern changes every so often between no stall,
    // sparse random stall, a fixed periodic pattern, and heavy stall.
    initial
    begin
        int mode;
        int hold;
        int phase;
        out_stall <= 1'b0;
        mode  = 0;
        hold  = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(64, 256);
            end
            hold--;
            phase++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= (phase % 7) < 3;
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Output checker: each character transfer is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_text.size() == 0)
            begin
                note_error($sformatf("unexpected character 0x%02h last %0b",
                                     character, last));
            end
            else
            begin
                want = pending_text.pop_front();
                chars_checked++;
                if (character !== want.character || last !== want.last)
                begin
                    note_error($sformatf(
                        "character 0x%02h last %0b, expected 0x%02h last %0b",
                        character, last, want.character, want.last));
                end
            end
        end
    end

    // Watchdog: too long a stretch with no transfer on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles with no transfer.", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

[sim.f]
rtl/core/sidec_pkg.sv
rtl/core/sidec_dabble.sv
rtl/core/signed_int_to_decimal_ascii.sv
dv/testbench.sv
